FILE: rtl/core/rfcc_pkg.sv
// ----------------------------------------------------------------------------
// rfcc_pkg
// Types, codes and the byte-wide CRC-16 update shared by the response frame
// CRC checker modules.
// ----------------------------------------------------------------------------
package rfcc_pkg;

    localparam logic [15:0] CRC_POLY   = 16'h8005;
    localparam logic [7:0]  BUSY_BYTE  = 8'hFF;
    localparam logic [7:0]  MIN_LENGTH = 8'd4;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_END     = 2'd1,
        KIND_BUSY    = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CRC_ERR = 2'd1,
        ST_BAD_LEN = 2'd2
    } status_t;

    // One received byte together with its resync flag.
    typedef struct packed {
        logic       resync;
        logic [7:0] rx_byte;
    } in_item_t;

    // What one byte leaves for the output side.
    typedef struct packed {
        logic        produce;
        kind_t       kind;
        logic [7:0]  data_byte;
        status_t     status;
        logic [15:0] crc_value;
    } result_t;

    // Feeds one byte, least significant bit first, into a left-shifting CRC.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] crc;
        logic        top;
        crc = crc_in;
        for (int i = 0; i < 8; i++)
        begin
            top = crc[15];
            crc = {crc[14:0], 1'b0};
            if (data[i] ^ top)
            begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

endpackage

FILE: rtl/core/response_frame_crc_checker.sv
// ----------------------------------------------------------------------------
// response_frame_crc_checker
// Checks length-prefixed response frames with a trailing CRC-16 (0x8005).
// ----------------------------------------------------------------------------
// Bytes enter on the slave stream with tuser[0] as resync; the first byte of a
// frame is its length. A length of 0xFF gives a busy marker, a length below
// four gives a bad-length end status, payload bytes come out one per transfer,
// and the last two bytes (little-endian CRC) give an ok or CRC-error end status
// carrying the computed CRC. One byte is taken per clock cycle: a byte passes
// the input register, is decided by combinational CRC and compare logic, and
// lands in the result register; the rate is set only by output back-pressure.
module response_frame_crc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
    input  logic        s_axis_tuser,  // [0] resync
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [7:0] data_byte, [9:8] status,
                                       // [25:10] crc_value, [31:26] zero
    output logic [1:0]  m_axis_tuser   // [1:0] kind
);
    import rfcc_pkg::*;

    in_item_t    in_item;
    in_item_t    held_item;
    logic        held_valid;
    logic        can_load;
    logic        step;
    result_t     result;
    kind_t       kind;
    logic [7:0]  data_byte;
    status_t     status;
    logic [15:0] crc_value;

    assign in_item.rx_byte = s_axis_tdata;
    assign in_item.resync  = s_axis_tuser;

    // A held byte is processed only when its result has room to land.
    assign step = held_valid && can_load;

    rfcc_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .held_valid(held_valid),
        .held_item (held_item),
        .take      (step)
    );

    rfcc_frame_ctl u_frame_ctl (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (held_item),
        .result(result)
    );

    rfcc_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step),
        .result   (result),
        .can_load (can_load),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .kind     (kind),
        .data_byte(data_byte),
        .status   (status),
        .crc_value(crc_value)
    );

    assign m_axis_tdata = {6'b000000, crc_value, status, data_byte};
    assign m_axis_tuser = kind;

endmodule

FILE: rtl/core/rfcc_in_stage.sv
// ----------------------------------------------------------------------------
// rfcc_in_stage
// Input register: holds one received byte until the frame logic takes it.
// ----------------------------------------------------------------------------
module rfcc_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rfcc_pkg::in_item_t in_item,
    output logic              held_valid,
    output rfcc_pkg::in_item_t held_item,
    input  logic              take
);
    import rfcc_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // A new transfer is taken when the register is empty or empties now.
    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

FILE: rtl/core/rfcc_frame_ctl.sv
// ----------------------------------------------------------------------------
// rfcc_frame_ctl
// Frame state and per-byte decision: length, payload, CRC bytes and status.
// ----------------------------------------------------------------------------
module rfcc_frame_ctl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  rfcc_pkg::in_item_t item,
    output rfcc_pkg::result_t  result
);
    import rfcc_pkg::*;

    logic        awaiting_reg;
    logic        awaiting_next;
    logic [7:0]  length_reg;
    logic [7:0]  length_next;
    logic [7:0]  position_reg;
    logic [7:0]  position_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [7:0]  crc_low_reg;
    logic [7:0]  crc_low_next;

    logic [8:0]  pos_plus2;
    logic [15:0] crc_of_byte;
    logic [15:0] crc_from_zero;

    assign pos_plus2     = {1'b0, position_reg} + 9'd2;
    assign crc_of_byte   = crc_feed(crc_reg, item.rx_byte);
    assign crc_from_zero = crc_feed(16'h0000, item.rx_byte);

    always_comb
    begin
        awaiting_next    = awaiting_reg;
        length_next      = length_reg;
        position_next    = position_reg;
        crc_next         = crc_reg;
        crc_low_next     = crc_low_reg;
        result.produce   = 1'b0;
        result.kind      = KIND_PAYLOAD;
        result.data_byte = 8'h00;
        result.status    = ST_OK;
        result.crc_value = 16'h0000;

        priority if (awaiting_reg || item.resync)
        begin
            priority if (item.rx_byte == BUSY_BYTE)
            begin
                awaiting_next  = 1'b1;
                result.produce = 1'b1;
                result.kind    = KIND_BUSY;
            end
            else if (item.rx_byte < MIN_LENGTH)
            begin
                awaiting_next    = 1'b1;
                result.produce   = 1'b1;
                result.kind      = KIND_END;
                result.status    = ST_BAD_LEN;
                result.crc_value = crc_from_zero;
            end
            else
            begin
                awaiting_next = 1'b0;
                length_next   = item.rx_byte;
                position_next = 8'd1;
                crc_next      = crc_from_zero;
                crc_low_next  = 8'h00;
            end
        end
        else if (pos_plus2 < {1'b0, length_reg})
        begin
            crc_next         = crc_of_byte;
            position_next    = position_reg + 8'd1;
            result.produce   = 1'b1;
            result.kind      = KIND_PAYLOAD;
            result.data_byte = item.rx_byte;
        end
        else if (pos_plus2 == {1'b0, length_reg})
        begin
            crc_low_next  = item.rx_byte;
            position_next = position_reg + 8'd1;
        end
        else
        begin
            awaiting_next    = 1'b1;
            position_next    = 8'd0;
            result.produce   = 1'b1;
            result.kind      = KIND_END;
            result.status    = ({item.rx_byte, crc_low_reg} == crc_reg) ? ST_OK : ST_CRC_ERR;
            result.crc_value = crc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg <= 1'b1;
            length_reg   <= 8'd0;
            position_reg <= 8'd0;
            crc_reg      <= 16'h0000;
            crc_low_reg  <= 8'h00;
        end
        else if (step)
        begin
            awaiting_reg <= awaiting_next;
            length_reg   <= length_next;
            position_reg <= position_next;
            crc_reg      <= crc_next;
            crc_low_reg  <= crc_low_next;
        end
    end

endmodule

FILE: rtl/core/rfcc_out_stage.sv
// ----------------------------------------------------------------------------
// rfcc_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module rfcc_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  rfcc_pkg::result_t result,
    output logic              can_load,
    output logic              out_valid,
    input  logic              out_ready,
    output rfcc_pkg::kind_t   kind,
    output logic [7:0]        data_byte,
    output rfcc_pkg::status_t status,
    output logic [15:0]       crc_value
);
    import rfcc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load ? result.produce : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && result.produce)
        begin
            result_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign kind      = result_reg.kind;
    assign data_byte = result_reg.data_byte;
    assign status    = result_reg.status;
    assign crc_value = result_reg.crc_value;

endmodule
